[hw/rtl/tfpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpr_pkg
// Shared types and constants of the trailer framed packet receiver.
// ----------------------------------------------------------------------------
package tfpr_pkg;

	// Four trailer bytes 1,2,3,4, oldest in the top byte.
	localparam logic [31:0] TRAILER_PATTERN = 32'h01020304;
	// Sum of the trailer bytes, taken back out of the running sum.
	localparam logic [7:0]  TRAILER_SUM     = 8'd10;
	// Checksum plus trailer: the fewest buffered bytes of a well-formed packet.
	localparam int unsigned MIN_FRAME_BYTES = 5;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHK  = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_RD   = 5'b01000,
		ST_LD   = 5'b10000
	} state_t;

endpackage

[hw/rtl/trailer_framed_packet_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trailer_framed_packet_receiver
// Buffers received bytes in a RAM, detects the 1,2,3,4 trailer, verifies the
// checksum and streams the payload out with a last marker or an empty flag.
// ----------------------------------------------------------------------------
// Flow control:
//   Ordinary bytes may arrive in every cycle while the receiver is in ST_IDLE.
//   A trailer byte blocks the input during the checksum read in ST_CHK and
//   ST_CMP (registered RAM read); an empty-packet result is loaded from ST_CMP
//   once the output is free. Payload readout follows ST_CMP and alternates a
//   RAM read in ST_RD and an output load in ST_LD, which waits for a free
//   output. Input stays blocked until the last payload byte is loaded.
//   Reset clears control state, fill count, sum and window; RAM is not cleared.
// ----------------------------------------------------------------------------
module trailer_framed_packet_receiver #(
	parameter int STORE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       last_byte,
	output logic       empty_packet
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	tfpr_pkg::state_t state_q, state_d;

	logic [CW-1:0] fill_q, fill_d;
	logic [7:0]    sum_q, sum_d;
	logic [31:0]   win_q, win_d;
	logic [AW-1:0] plen_q, plen_d;
	logic [AW-1:0] idx_q, idx_d;

	logic          out_valid_q, out_valid_d;
	logic [7:0]    payload_q, payload_d;
	logic          last_q, last_d;
	logic          empty_q, empty_d;

	logic          in_xfer;
	logic          out_free;
	logic [CW-1:0] fill_wr;
	logic [CW-1:0] fill_inc;
	logic [7:0]    sum_inc;
	logic [31:0]   win_inc;
	logic          trailer_hit;
	logic          short_frame;
	logic [7:0]    chk_diff;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	tfpr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == tfpr_pkg::ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// A full store wraps to the first entry; the sum keeps running.
	assign fill_wr     = (fill_q == CW'(STORE_DEPTH)) ? '0 : fill_q;
	assign fill_inc    = fill_wr + CW'(1);
	assign sum_inc     = sum_q + rx_byte;
	assign win_inc     = {win_q[23:0], rx_byte};
	assign trailer_hit = (win_inc == tfpr_pkg::TRAILER_PATTERN);
	assign short_frame = (fill_inc < CW'(tfpr_pkg::MIN_FRAME_BYTES));

	assign ram_we    = in_xfer;
	assign ram_waddr = fill_wr[AW-1:0];
	assign ram_raddr = (state_q == tfpr_pkg::ST_RD || state_q == tfpr_pkg::ST_LD)
		? idx_q : plen_q;

	assign chk_diff = sum_q - ram_rdata - tfpr_pkg::TRAILER_SUM;

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		sum_d       = sum_q;
		win_d       = win_q;
		plen_d      = plen_q;
		idx_d       = idx_q;
		out_valid_d = out_valid_q && !out_ready;
		payload_d   = payload_q;
		last_d      = last_q;
		empty_d     = empty_q;

		unique case (state_q)
			tfpr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					fill_d = fill_inc;
					sum_d  = sum_inc;
					win_d  = win_inc;
					if (trailer_hit) begin
						if (short_frame) begin
							fill_d = '0;
							sum_d  = '0;
						end else begin
							plen_d  = AW'(fill_inc - CW'(tfpr_pkg::MIN_FRAME_BYTES));
							state_d = tfpr_pkg::ST_CHK;
						end
					end
				end
			end
			tfpr_pkg::ST_CHK: begin
				state_d = tfpr_pkg::ST_CMP;
			end
			tfpr_pkg::ST_CMP: begin
				if (chk_diff != ram_rdata) begin
					fill_d  = '0;
					sum_d   = '0;
					state_d = tfpr_pkg::ST_IDLE;
				end else if (plen_q != '0) begin
					idx_d   = '0;
					state_d = tfpr_pkg::ST_RD;
				end else if (out_free) begin
					out_valid_d = 1'b1;
					payload_d   = '0;
					last_d      = 1'b1;
					empty_d     = 1'b1;
					fill_d      = '0;
					sum_d       = '0;
					state_d     = tfpr_pkg::ST_IDLE;
				end
			end
			tfpr_pkg::ST_RD: begin
				state_d = tfpr_pkg::ST_LD;
			end
			tfpr_pkg::ST_LD: begin
				// Read data stays put while the address holds, so waiting is safe.
				if (out_free) begin
					out_valid_d = 1'b1;
					payload_d   = ram_rdata;
					empty_d     = 1'b0;
					last_d      = (idx_q == plen_q - AW'(1));
					idx_d       = idx_q + AW'(1);
					if (idx_q == plen_q - AW'(1)) begin
						fill_d  = '0;
						sum_d   = '0;
						state_d = tfpr_pkg::ST_IDLE;
					end else begin
						state_d = tfpr_pkg::ST_RD;
					end
				end
			end
			default: begin
				state_d = tfpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfpr_pkg::ST_IDLE;
			fill_q      <= '0;
			sum_q       <= '0;
			win_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			sum_q       <= sum_d;
			win_q       <= win_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		plen_q    <= plen_d;
		idx_q     <= idx_d;
		payload_q <= payload_d;
		last_q    <= last_d;
		empty_q   <= empty_d;
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign last_byte    = last_q;
	assign empty_packet = empty_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(STORE_DEPTH))
		else $error("fill count beyond store depth");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_packet) |-> (last_byte && payload_byte == 8'd0))
		else $error("empty-packet result not marked last with zero byte");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfpr_pkg::ST_RD || state_q == tfpr_pkg::ST_LD) |-> (idx_q < plen_q))
		else $error("readout index beyond payload length");

	a_short_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && trailer_hit && short_frame) |=> (fill_q == '0 && sum_q == '0))
		else $error("short trailer did not clear the packet");

	a_trailer_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && trailer_hit && !short_frame) |=> (state_q == tfpr_pkg::ST_CHK))
		else $error("valid trailer did not start checksum read");

endmodule

[hw/rtl/tfpr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfpr_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
